// ----- hdl/pcsm_pkg.sv -----
// Shared types, codes and defaults of the p-code stack machine.
package pcsm_pkg;

  localparam int CODE_DEPTH_DEF  = 256;
  localparam int STACK_DEPTH_DEF = 512;
  localparam int MAX_NEST_DEF    = 3;

  localparam int IDX_W = 34;  // signed index math: base/top plus a 32-bit displacement

  // commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // opcodes
  localparam logic [2:0] OP_LIT = 3'd0;
  localparam logic [2:0] OP_OPR = 3'd1;
  localparam logic [2:0] OP_LOD = 3'd2;
  localparam logic [2:0] OP_STO = 3'd3;
  localparam logic [2:0] OP_CAL = 3'd4;
  localparam logic [2:0] OP_INT = 3'd5;
  localparam logic [2:0] OP_JMP = 3'd6;
  localparam logic [2:0] OP_JPC = 3'd7;

  // OPR function codes
  localparam logic [3:0] OPR_RET = 4'd0;
  localparam logic [3:0] OPR_NEG = 4'd1;
  localparam logic [3:0] OPR_ADD = 4'd2;
  localparam logic [3:0] OPR_SUB = 4'd3;
  localparam logic [3:0] OPR_MUL = 4'd4;
  localparam logic [3:0] OPR_DIV = 4'd5;
  localparam logic [3:0] OPR_ODD = 4'd6;
  localparam logic [3:0] OPR_EQ  = 4'd8;
  localparam logic [3:0] OPR_NE  = 4'd9;
  localparam logic [3:0] OPR_LT  = 4'd10;
  localparam logic [3:0] OPR_GE  = 4'd11;
  localparam logic [3:0] OPR_GT  = 4'd12;
  localparam logic [3:0] OPR_LE  = 4'd13;

  // halt status
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_PAST   = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_BADOPR = 3'd4;
  localparam logic [2:0] ST_STACK  = 3'd5;

  typedef struct packed {
    logic       start;
    logic [3:0] fn;
  } alu_req_t;

endpackage

// ----- hdl/pcsm_alu.sv -----
// Shared arithmetic/compare unit with an iterative restoring divider.
module pcsm_alu
  import pcsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] ym_r, ym_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] res_r, res_nxt;

  logic [32:0] rsh;
  logic [32:0] trial;
  logic [31:0] quo_step;
  logic [32:0] rem_step;
  logic [31:0] simple;

  always_comb begin
    rsh   = {rem_r[31:0], quo_r[31]};
    trial = rsh - {1'b0, ym_r};
    if (!trial[32]) begin
      rem_step = trial;
      quo_step = {quo_r[30:0], 1'b1};
    end else begin
      rem_step = rsh;
      quo_step = {quo_r[30:0], 1'b0};
    end
  end

  always_comb begin
    unique case (req.fn)
      OPR_ADD: simple = x_i + y_i;
      OPR_SUB: simple = x_i - y_i;
      OPR_MUL: simple = x_i * y_i;
      OPR_EQ:  simple = {31'd0, x_i == y_i};
      OPR_NE:  simple = {31'd0, x_i != y_i};
      OPR_LT:  simple = {31'd0, $signed(x_i) < $signed(y_i)};
      OPR_GE:  simple = {31'd0, $signed(x_i) >= $signed(y_i)};
      OPR_GT:  simple = {31'd0, $signed(x_i) > $signed(y_i)};
      OPR_LE:  simple = {31'd0, $signed(x_i) <= $signed(y_i)};
      default: simple = 32'd0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ym_nxt   = ym_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    if (busy_r) begin
      rem_nxt = rem_step;
      quo_nxt = quo_step;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (32'd0 - quo_step) : quo_step;
      end
    end else if (req.start) begin
      if (req.fn == OPR_DIV) begin
        busy_nxt = 1'b1;
        cnt_nxt  = 5'd0;
        rem_nxt  = 33'd0;
        quo_nxt  = x_i[31] ? (32'd0 - x_i) : x_i;
        ym_nxt   = y_i[31] ? (32'd0 - y_i) : y_i;
        neg_nxt  = x_i[31] ^ y_i[31];
      end else begin
        done_nxt = 1'b1;
        res_nxt  = simple;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ym_r  <= ym_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

// ----- hdl/pcode_stack_machine_top.sv -----
// Top level of the PL/0 p-code stack machine: sequencer, code and stack memories.
//
// One command transaction in gives one result transaction out. A step's
// length depends on its opcode: LOD, STO and CAL walk the static links one
// level at a time (up to MAX_NEST), and OPR divide runs the shared unit's
// iterative divider. The single-port-read stack memory sets the pace: every
// operand and every link is one registered read. Restart writes zero to
// every stack word but word 0, which gets all ones, one write per cycle; the
// same clearing pass runs after reset, during which in_tready stays low.
// Configuration writes are taken at any time. A finished result waits in the
// output register while the next command is accepted.
module pcode_stack_machine_top
  import pcsm_pkg::*;
#(
  parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int MAX_NEST    = MAX_NEST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // load_addr[7:0], load_opcode[10:8], load_level[12:11],
                                  // load_disp[44:13], zero fill
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pc[7:0], top[16:8], top_value[48:17],
                                  // frame_base[57:49], zero fill
  output logic [2:0]  out_tuser,  // status[2:0]
  // code_length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  localparam int CAW = $clog2(CODE_DEPTH);
  localparam int PCW = $clog2(CODE_DEPTH + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int IW  = IDX_W;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_CLEAR = 20'h00002,
    S_FETCH = 20'h00004,
    S_DISP  = 20'h00008,
    S_WALK  = 20'h00010,
    S_WALKW = 20'h00020,
    S_LINK  = 20'h00040,
    S_LODW  = 20'h00080,
    S_STOW  = 20'h00100,
    S_JPCW  = 20'h00200,
    S_RET1  = 20'h00400,
    S_RET2  = 20'h00800,
    S_UNRD  = 20'h01000,
    S_BINY  = 20'h02000,
    S_BINX  = 20'h04000,
    S_ALU   = 20'h08000,
    S_CAL2  = 20'h10000,
    S_CAL3  = 20'h20000,
    S_FIN   = 20'h40000,
    S_RES   = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  // architectural state
  logic [PCW-1:0] pc_r, pc_nxt;
  logic [SW-1:0]  top_r, top_nxt;
  logic [SW-1:0]  base_r, base_nxt;
  logic [2:0]     halt_r, halt_nxt;
  logic [8:0]     code_len_r;

  // per-step working registers
  logic [2:0]          op_r, op_nxt;
  logic [1:0]          lv_r, lv_nxt;
  logic [31:0]         d_r, d_nxt;
  logic [31:0]         y_r, y_nxt;
  logic signed [IW-1:0] lk_r, lk_nxt;
  logic signed [IW-1:0] addr_r, addr_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [SW-1:0]       clr_r, clr_nxt;
  logic                clr_rsp_r, clr_rsp_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  // memories
  logic [36:0] code_mem [CODE_DEPTH];
  logic [36:0] code_q;
  logic        code_we;
  logic [CAW-1:0] code_waddr;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] stack_q;
  logic        st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [31:0] st_wdata;

  alu_req_t    alu_req;
  logic        alu_done;
  logic [31:0] alu_res;

  logic in_acc;
  logic [1:0]  cmd;
  logic [7:0]  ld_addr;
  logic [31:0] ld_addr32;
  logic [31:0] pc32, top32, base32;

  function automatic logic signed [IW-1:0] uidx(input logic [SW-1:0] v);
    return $signed(IW'(v));
  endfunction

  function automatic logic signed [IW-1:0] sx(input logic [31:0] v);
    return IW'($signed(v));
  endfunction

  function automatic logic in_stack(input logic signed [IW-1:0] v);
    return (v >= 0) && (v < $signed(IW'(STACK_DEPTH)));
  endfunction

  function automatic logic in_code(input logic signed [IW-1:0] v);
    return (v >= 0) && (v < $signed(IW'(CODE_DEPTH)));
  endfunction

  function automatic logic [2:0] run_status(input logic [PCW-1:0] np);
    return (np == '0) ? ST_DONE : ST_OK;
  endfunction

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd       = in_tuser;
  assign ld_addr   = in_tdata[7:0];
  assign ld_addr32 = 32'(ld_addr);
  assign pc32      = 32'(pc_r);
  assign top32     = 32'(top_r);
  assign base32    = 32'(base_r);

  assign code_we    = in_acc && (cmd == CMD_LOAD) && (ld_addr32 < 32'(CODE_DEPTH));
  assign code_waddr = ld_addr32[CAW-1:0];

  pcsm_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .x_i    (stack_q),
    .y_i    (y_r),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // code memory: written by loads, read at the pc
  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_waddr] <= {in_tdata[10:8], in_tdata[12:11], in_tdata[44:13]};
    end
    code_q <= code_mem[pc_r[CAW-1:0]];
  end

  // stack memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    stack_q <= stack_mem[st_raddr];
  end

  always_comb begin
    logic signed [IW-1:0] t_s;
    logic signed [IW-1:0] b_s;
    logic signed [IW-1:0] dd;
    logic signed [IW-1:0] nt;
    logic signed [IW-1:0] a;
    logic [PCW-1:0]       np;
    logic                 binop;

    t_s   = uidx(top_r);
    b_s   = uidx(base_r);
    dd    = sx(d_r);
    np    = pc_r + PCW'(1);
    nt    = '0;
    a     = '0;
    binop = ((d_r >= 32'd2) && (d_r <= 32'd5)) || ((d_r >= 32'd8) && (d_r <= 32'd13));

    state_nxt     = state_r;
    pc_nxt        = pc_r;
    top_nxt       = top_r;
    base_nxt      = base_r;
    halt_nxt      = halt_r;
    op_nxt        = op_r;
    lv_nxt        = lv_r;
    d_nxt         = d_r;
    y_nxt         = y_r;
    lk_nxt        = lk_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    clr_rsp_nxt   = clr_rsp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    st_we         = 1'b0;
    st_waddr      = top_r;
    st_wdata      = 32'd0;
    st_raddr      = top_r;
    alu_req.start = 1'b0;
    alu_req.fn    = d_r[3:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_LOAD: state_nxt = S_FIN;
            CMD_STEP: begin
              if (halt_r != ST_OK) begin
                state_nxt = S_FIN;
              end else if ((pc32 >= 32'(code_len_r)) || (pc32 >= 32'(CODE_DEPTH))) begin
                halt_nxt  = ST_PAST;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            CMD_RESTART: begin
              clr_nxt     = '0;
              clr_rsp_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = (clr_r == '0) ? 32'hFFFF_FFFF : 32'd0;
        clr_nxt  = clr_r + SW'(1);
        if (32'(clr_r) == 32'(STACK_DEPTH - 1)) begin
          pc_nxt    = '0;
          top_nxt   = '0;
          base_nxt  = SW'(1);
          halt_nxt  = ST_OK;
          state_nxt = clr_rsp_r ? S_FIN : S_IDLE;
        end
      end

      S_FETCH: begin
        op_nxt    = code_q[36:34];
        lv_nxt    = code_q[33:32];
        d_nxt     = code_q[31:0];
        state_nxt = S_DISP;
      end

      S_DISP: begin
        state_nxt = S_FIN;
        unique case (op_r)
          OP_LIT: begin
            nt = t_s + IW'(1);
            if (!in_stack(nt)) begin
              halt_nxt = ST_STACK;
            end else begin
              st_we    = 1'b1;
              st_waddr = nt[SW-1:0];
              st_wdata = d_r;
              top_nxt  = nt[SW-1:0];
              pc_nxt   = np;
              halt_nxt = run_status(np);
            end
          end
          OP_OPR: begin
            if (d_r == 32'd0) begin
              nt = b_s - IW'(1);
              if (!in_stack(nt) || !in_stack(nt + IW'(3))) begin
                halt_nxt = ST_STACK;
              end else begin
                a         = nt + IW'(2);
                st_raddr  = a[SW-1:0];
                addr_nxt  = nt;
                state_nxt = S_RET1;
              end
            end else if ((d_r == 32'd1) || (d_r == 32'd6)) begin
              state_nxt = S_UNRD;
            end else if (binop) begin
              nt = t_s - IW'(1);
              if (!in_stack(nt)) begin
                halt_nxt = ST_STACK;
              end else begin
                state_nxt = S_BINY;
              end
            end else begin
              halt_nxt = ST_BADOPR;
            end
          end
          OP_LOD, OP_STO, OP_CAL: begin
            lk_nxt    = b_s;
            cnt_nxt   = (32'(lv_r) > 32'(MAX_NEST)) ? 4'(MAX_NEST) : 4'(lv_r);
            state_nxt = S_WALK;
          end
          OP_INT: begin
            nt = t_s + dd;
            if (!in_stack(nt)) begin
              halt_nxt = ST_STACK;
            end else begin
              top_nxt  = nt[SW-1:0];
              pc_nxt   = np;
              halt_nxt = run_status(np);
            end
          end
          OP_JMP: begin
            if (!in_code(dd)) begin
              halt_nxt = ST_PAST;
            end else begin
              pc_nxt   = dd[PCW-1:0];
              halt_nxt = run_status(dd[PCW-1:0]);
            end
          end
          OP_JPC: begin
            nt = t_s - IW'(1);
            if (!in_stack(nt)) begin
              halt_nxt = ST_STACK;
            end else begin
              state_nxt = S_JPCW;
            end
          end
          default: halt_nxt = ST_BADOPR;
        endcase
      end

      S_UNRD: begin
        st_we    = 1'b1;
        st_wdata = (d_r == 32'd1) ? (32'd0 - stack_q) : {31'd0, stack_q[0]};
        pc_nxt   = np;
        halt_nxt = run_status(np);
        state_nxt = S_FIN;
      end

      S_BINY: begin
        y_nxt     = stack_q;
        nt        = t_s - IW'(1);
        st_raddr  = nt[SW-1:0];
        state_nxt = S_BINX;
      end

      S_BINX: begin
        if ((d_r == 32'(OPR_DIV)) && (y_r == 32'd0)) begin
          halt_nxt  = ST_DIVZ;
          state_nxt = S_FIN;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_ALU;
        end
      end

      S_ALU: begin
        if (alu_done) begin
          nt        = t_s - IW'(1);
          st_we     = 1'b1;
          st_waddr  = nt[SW-1:0];
          st_wdata  = alu_res;
          top_nxt   = nt[SW-1:0];
          pc_nxt    = np;
          halt_nxt  = run_status(np);
          state_nxt = S_FIN;
        end
      end

      S_RET1: begin
        a = sx(stack_q);
        if (!in_stack(a)) begin
          halt_nxt  = ST_STACK;
          state_nxt = S_FIN;
        end else begin
          lk_nxt    = a;
          nt        = addr_r + IW'(3);
          st_raddr  = nt[SW-1:0];
          state_nxt = S_RET2;
        end
      end

      S_RET2: begin
        a         = sx(stack_q);
        state_nxt = S_FIN;
        if (!in_code(a)) begin
          halt_nxt = ST_PAST;
        end else begin
          top_nxt  = addr_r[SW-1:0];
          base_nxt = lk_r[SW-1:0];
          pc_nxt   = a[PCW-1:0];
          halt_nxt = run_status(a[PCW-1:0]);
        end
      end

      S_WALK: begin
        if (cnt_r == 4'd0) begin
          state_nxt = S_LINK;
        end else if (!in_stack(lk_r)) begin
          halt_nxt  = ST_STACK;
          state_nxt = S_FIN;
        end else begin
          st_raddr  = lk_r[SW-1:0];
          state_nxt = S_WALKW;
        end
      end

      S_WALKW: begin
        lk_nxt    = sx(stack_q);
        cnt_nxt   = cnt_r - 4'd1;
        state_nxt = S_WALK;
      end

      S_LINK: begin
        state_nxt = S_FIN;
        a         = lk_r + dd;
        if (!in_stack(lk_r)) begin
          halt_nxt = ST_STACK;
        end else begin
          unique case (op_r)
            OP_LOD: begin
              nt = t_s + IW'(1);
              if (!in_stack(a) || !in_stack(nt)) begin
                halt_nxt = ST_STACK;
              end else begin
                st_raddr  = a[SW-1:0];
                state_nxt = S_LODW;
              end
            end
            OP_STO: begin
              nt = t_s - IW'(1);
              if (!in_stack(a) || !in_stack(nt)) begin
                halt_nxt = ST_STACK;
              end else begin
                addr_nxt  = a;
                state_nxt = S_STOW;
              end
            end
            OP_CAL: begin
              nt = t_s + IW'(1);
              if (!in_stack(t_s + IW'(3))) begin
                halt_nxt = ST_STACK;
              end else if (!in_code(dd)) begin
                halt_nxt = ST_PAST;
              end else begin
                st_we     = 1'b1;
                st_waddr  = nt[SW-1:0];
                st_wdata  = lk_r[31:0];
                state_nxt = S_CAL2;
              end
            end
            default: halt_nxt = ST_BADOPR;
          endcase
        end
      end

      S_LODW: begin
        nt        = t_s + IW'(1);
        st_we     = 1'b1;
        st_waddr  = nt[SW-1:0];
        st_wdata  = stack_q;
        top_nxt   = nt[SW-1:0];
        pc_nxt    = np;
        halt_nxt  = run_status(np);
        state_nxt = S_FIN;
      end

      S_STOW: begin
        nt        = t_s - IW'(1);
        st_we     = 1'b1;
        st_waddr  = addr_r[SW-1:0];
        st_wdata  = stack_q;
        top_nxt   = nt[SW-1:0];
        pc_nxt    = np;
        halt_nxt  = run_status(np);
        state_nxt = S_FIN;
      end

      S_CAL2: begin
        nt        = t_s + IW'(2);
        st_we     = 1'b1;
        st_waddr  = nt[SW-1:0];
        st_wdata  = base32;
        state_nxt = S_CAL3;
      end

      S_CAL3: begin
        nt        = t_s + IW'(3);
        st_we     = 1'b1;
        st_waddr  = nt[SW-1:0];
        st_wdata  = 32'(np);
        a         = t_s + IW'(1);
        base_nxt  = a[SW-1:0];
        pc_nxt    = dd[PCW-1:0];
        halt_nxt  = run_status(dd[PCW-1:0]);
        state_nxt = S_FIN;
      end

      S_JPCW: begin
        nt        = t_s - IW'(1);
        state_nxt = S_FIN;
        if (stack_q == 32'd0) begin
          if (!in_code(dd)) begin
            halt_nxt = ST_PAST;
          end else begin
            top_nxt  = nt[SW-1:0];
            pc_nxt   = dd[PCW-1:0];
            halt_nxt = run_status(dd[PCW-1:0]);
          end
        end else begin
          top_nxt  = nt[SW-1:0];
          pc_nxt   = np;
          halt_nxt = run_status(np);
        end
      end

      // read of the top word is in flight
      S_FIN: state_nxt = S_RES;

      S_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = halt_r;
          out_data_nxt  = {6'd0, base32[8:0], stack_q, top32[8:0], pc32[7:0]};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
      code_len_r  <= 9'd0;
      pc_r        <= '0;
      top_r       <= '0;
      base_r      <= SW'(1);
      halt_r      <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        code_len_r <= cfg_data;
      end
      pc_r   <= pc_nxt;
      top_r  <= top_nxt;
      base_r <= base_nxt;
      halt_r <= halt_nxt;
    end
    op_r       <= op_nxt;
    lv_r       <= lv_nxt;
    d_r        <= d_nxt;
    y_r        <= y_nxt;
    lk_r       <= lk_nxt;
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
